// ===== rtl/midi_to_ble_midi_framer_assert.svh =====
// ----------------------------------------------------------------------------
// midi to ble-midi framer assertion macros
// shared property forms, clocked on i_clk and disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef MIDI_TO_BLE_MIDI_FRAMER_ASSERT_SVH
`define MIDI_TO_BLE_MIDI_FRAMER_ASSERT_SVH

// same-cycle implication
`define MBF_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mbf: same-cycle check failed");

// next-cycle implication
`define MBF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mbf: next-cycle check failed");

`endif

// ===== rtl/mbf_pkg.sv =====
// ----------------------------------------------------------------------------
// mbf_pkg
// types, constants and helpers shared by the midi to ble-midi framer
// ----------------------------------------------------------------------------
package mbf_pkg;

    // sysex bytes allowed in one packet before a forced send
    localparam int unsigned SYSEX_FLUSH_COUNT = 18;

    // job queue between front and back
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    // input item kinds
    localparam logic KIND_MIDI = 1'b0;
    localparam logic KIND_SENT = 1'b1;

    // byte codes
    localparam logic [7:0] BLE_STAMP     = 8'h80;
    localparam logic [7:0] ST_ACT_SENSE  = 8'hFE;
    localparam logic [7:0] ST_CLOCK      = 8'hF8;
    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_EOX        = 8'hF7;
    localparam logic [7:0] ST_NONE       = 8'h00;
    localparam logic [7:0] STATUS_MASK   = 8'hF0;
    localparam logic [7:0] CHAN_MASK     = 8'h0F;
    localparam logic [7:0] ST_NOTE_OFF   = 8'h80;
    localparam logic [7:0] ST_NOTE_ON    = 8'h90;
    localparam logic [7:0] ST_POLY_PRESS = 8'hA0;
    localparam logic [7:0] ST_CTRL       = 8'hB0;
    localparam logic [7:0] ST_PROG       = 8'hC0;
    localparam logic [7:0] ST_CHAN_PRESS = 8'hD0;
    localparam logic [7:0] ST_BEND       = 8'hE0;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       flush_after;
        logic       last;
    } t_out_item;

    // one classified message: header/stamp bytes, then payload bytes
    typedef struct packed {
        logic [1:0]      hdr_cnt;
        logic [1:0]      pay_cnt;
        logic [2:0][7:0] pay;
        logic            flush;
    } t_job;

    function automatic logic is_three_byte(input logic [7:0] s);
        return (s == ST_NOTE_OFF) || (s == ST_NOTE_ON) || (s == ST_POLY_PRESS) ||
               (s == ST_CTRL) || (s == ST_BEND);
    endfunction

    function automatic logic is_two_byte(input logic [7:0] s);
        return (s == ST_PROG) || (s == ST_CHAN_PRESS);
    endfunction

endpackage

// ===== rtl/mbf_front.sv =====
// ----------------------------------------------------------------------------
// mbf_front
// parses serial midi bytes, keeps running status and packet state, and
// turns each item into at most one output job for the back end
// ----------------------------------------------------------------------------
module mbf_front
    import mbf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_job_push,
    output t_job     o_job
);

    logic [7:0] r_running_status, n_running_status;
    logic [3:0] r_channel_number, n_channel_number;
    logic [1:0] r_bytes_pending,  n_bytes_pending;
    logic [7:0] r_held_data,      n_held_data;
    logic       r_packet_open,    n_packet_open;
    logic [4:0] r_sysex_fill,     n_sysex_fill;

    logic [7:0] w_b;
    logic [7:0] w_st;
    logic [4:0] w_fill_base;
    logic [4:0] w_fill_inc;
    logic [1:0] w_head;
    t_job       w_job;

    assign w_b         = i_item.byte_value;
    assign w_st        = r_running_status | {4'h0, r_channel_number};
    assign w_head      = r_packet_open ? 2'd1 : 2'd2;
    assign w_fill_base = r_packet_open ? r_sysex_fill : 5'd1;
    assign w_fill_inc  = w_fill_base + 5'd1;

    // classify the item and work out the next parser state
    always_comb begin
        n_running_status = r_running_status;
        n_channel_number = r_channel_number;
        n_bytes_pending  = r_bytes_pending;
        n_held_data      = r_held_data;
        n_packet_open    = r_packet_open;
        n_sysex_fill     = r_sysex_fill;
        w_job            = '0;
        if (i_item.kind == KIND_SENT) begin
            n_packet_open = 1'b0;
        end else if ((w_b == ST_ACT_SENSE) || (w_b == ST_CLOCK)) begin
            w_job.hdr_cnt = w_head;
            w_job.pay_cnt = 2'd1;
            w_job.pay[0]  = w_b;
            n_packet_open = 1'b1;
        end else if (w_b == ST_SYSEX) begin
            n_running_status = ST_SYSEX;
            n_sysex_fill     = 5'd3;
            w_job.hdr_cnt    = w_head;
            w_job.pay_cnt    = 2'd1;
            w_job.pay[0]     = ST_SYSEX;
            n_packet_open    = 1'b1;
        end else if (w_b == ST_EOX) begin
            n_running_status = ST_NONE;
            w_job.hdr_cnt    = w_head;
            w_job.pay_cnt    = 2'd1;
            w_job.pay[0]     = ST_EOX;
            n_packet_open    = 1'b1;
        end else if (r_running_status == ST_SYSEX) begin
            // streamed sysex data, single header when the packet is closed
            w_job.hdr_cnt = r_packet_open ? 2'd0 : 2'd1;
            w_job.pay_cnt = 2'd1;
            w_job.pay[0]  = w_b;
            if (w_fill_inc > 5'(SYSEX_FLUSH_COUNT)) begin
                w_job.flush   = 1'b1;
                n_sysex_fill  = 5'd0;
                n_packet_open = 1'b0;
            end else begin
                n_sysex_fill  = w_fill_inc;
                n_packet_open = 1'b1;
            end
        end else if (w_b[7]) begin
            n_running_status = w_b & STATUS_MASK;
            n_channel_number = 4'(w_b & CHAN_MASK);
            if (is_three_byte(w_b & STATUS_MASK)) begin
                n_bytes_pending = 2'd2;
            end else if (is_two_byte(w_b & STATUS_MASK)) begin
                n_bytes_pending = 2'd1;
            end
        end else if (r_bytes_pending == 2'd1) begin
            n_bytes_pending = 2'd0;
            if (is_three_byte(r_running_status)) begin
                w_job.hdr_cnt   = w_head;
                w_job.pay_cnt   = 2'd3;
                w_job.pay[0]    = w_st;
                w_job.pay[1]    = r_held_data;
                w_job.pay[2]    = w_b;
                n_packet_open   = 1'b1;
                n_bytes_pending = 2'd2;
            end else if (is_two_byte(r_running_status)) begin
                w_job.hdr_cnt   = w_head;
                w_job.pay_cnt   = 2'd2;
                w_job.pay[0]    = w_st;
                w_job.pay[1]    = w_b;
                n_packet_open   = 1'b1;
                n_bytes_pending = 2'd1;
            end
        end else if (r_bytes_pending == 2'd2) begin
            n_held_data     = w_b;
            n_bytes_pending = 2'd1;
        end
    end

    assign o_job      = w_job;
    assign o_job_push = i_accept && (w_job.pay_cnt != 2'd0);

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_status <= ST_NONE;
            r_channel_number <= '0;
            r_bytes_pending  <= '0;
            r_held_data      <= '0;
            r_packet_open    <= 1'b0;
            r_sysex_fill     <= '0;
        end else if (i_accept) begin
            r_running_status <= n_running_status;
            r_channel_number <= n_channel_number;
            r_bytes_pending  <= n_bytes_pending;
            r_held_data      <= n_held_data;
            r_packet_open    <= n_packet_open;
            r_sysex_fill     <= n_sysex_fill;
        end
    end

endmodule

// ===== rtl/mbf_fifo.sv =====
// ----------------------------------------------------------------------------
// mbf_fifo
// short job queue that decouples the parser from the byte emitter
// ----------------------------------------------------------------------------
module mbf_fifo
    import mbf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_head
);

    t_job             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (FIFO_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (FIFO_AW+1)'(1);
            end
        end
    end

endmodule

// ===== rtl/mbf_back.sv =====
// ----------------------------------------------------------------------------
// mbf_back
// expands each job into header, timestamp and payload bytes in an output register,
// one per cycle while a job is queued and that register is free or being popped
// ----------------------------------------------------------------------------
module mbf_back
    import mbf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_job      i_head,
    output logic      o_pop,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);

`include "midi_to_ble_midi_framer_assert.svh"

    logic [2:0] r_idx;
    logic       r_out_valid;
    t_out_item  r_out;

    logic [2:0] w_total;
    logic [1:0] w_pidx;
    logic       w_is_last;
    logic       w_adv;
    t_out_item  w_next;

    assign w_total   = {1'b0, i_head.hdr_cnt} + {1'b0, i_head.pay_cnt};
    assign w_pidx    = 2'(r_idx - {1'b0, i_head.hdr_cnt});
    assign w_is_last = (r_idx == (w_total - 3'd1));
    assign w_adv     = !i_empty && (!r_out_valid || i_pop);

    // pick the byte at the current position of the job
    always_comb begin
        w_next = '0;
        if (r_idx < {1'b0, i_head.hdr_cnt}) begin
            w_next.out_byte = BLE_STAMP;
        end else begin
            case (w_pidx)
                2'd0:    w_next.out_byte = i_head.pay[0];
                2'd1:    w_next.out_byte = i_head.pay[1];
                2'd2:    w_next.out_byte = i_head.pay[2];
                default: w_next.out_byte = i_head.pay[0];
            endcase
            w_next.flush_after = i_head.flush && w_is_last;
        end
        w_next.last = w_is_last;
    end

    assign o_pop   = w_adv && w_is_last;
    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    // position within job and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_idx       <= w_is_last ? 3'd0 : r_idx + 3'd1;
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_next;
        end
    end

    // checks
    `MBF_ASSERT_IMPLY(a_job_has_payload, !i_empty, i_head.pay_cnt != 2'd0)
    `MBF_ASSERT_IMPLY(a_idx_in_job, !i_empty, r_idx < w_total)
    `MBF_ASSERT_IMPLY(a_flush_on_last, r_out_valid && r_out.flush_after, r_out.last)
    `MBF_ASSERT_NEXT(a_idx_restart, o_pop, r_idx == 3'd0)

endmodule

// ===== rtl/midi_to_ble_midi_framer.sv =====
// path: an item's job passes the job queue, then the emitter's output register, to the outputs
// throughput: one result byte per cycle while pop keeps the output register free; an item
// causes one to five result bytes, or none, all sent out by the single-byte emitter;
// four jobs queue in between, so new items are taken while earlier bytes still go out
// reset: synchronous active-low i_rst_n clears parser state and empties both queues
// ----------------------------------------------------------------------------
// midi_to_ble_midi_framer
// serial midi byte stream in, ble-midi packet bytes out
// ----------------------------------------------------------------------------
module midi_to_ble_midi_framer
    import mbf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);

    logic w_accept;
    logic w_job_push;
    t_job w_job;
    logic w_q_full;
    logic w_q_empty;
    logic w_q_pop;
    t_job w_q_head;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    // parser
    mbf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_item     (i_item),
        .o_job_push (w_job_push),
        .o_job      (w_job)
    );

    // job queue
    mbf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_head  (w_q_head)
    );

    // byte emitter
    mbf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_q_empty),
        .i_head  (w_q_head),
        .o_pop   (w_q_pop),
        .o_empty (empty),
        .i_pop   (pop),
        .o_item  (o_item)
    );

endmodule

// ===== bench/midi_to_ble_midi_framer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_to_ble_midi_framer_test
// drives serial midi bytes and packet-sent items into the framer, predicts the
// ble-midi bytes from its own parser state, and checks every popped item in order
// ----------------------------------------------------------------------------
module midi_to_ble_midi_framer_test;
    import mbf_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  i_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_item;

    // predicted parser state
    logic [7:0] run_status;
    logic [3:0] chan;
    logic [1:0] data_left;
    logic [7:0] first_data;
    logic       pkt_open;
    logic [4:0] sysex_count;

    // bytes caused by one input item, then the queue of bytes still to arrive
    t_out_item  burst [0:4];
    int         burst_len;
    t_out_item  ble_bytes_due [$];

    int send_idle_pct = 28;
    int recv_idle_pct = 51;
    int items_sent = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;

    midi_to_ble_midi_framer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_item)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // number of data bytes a channel status takes
    function automatic int status_data_len(input logic [7:0] status);
        case (status)
            ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRESS, ST_CTRL, ST_BEND: return 2;
            ST_PROG, ST_CHAN_PRESS: return 1;
            default: return 0;
        endcase
    endfunction

    task automatic put_byte(input logic [7:0] value, input logic flush);
        burst[burst_len] = {value, flush, 1'b0};
        burst_len++;
    endtask

    // header plus stamp when opening a packet, else just the stamp
    task automatic put_head();
        if (!pkt_open) begin
            put_byte(BLE_STAMP, 1'b0);
            put_byte(BLE_STAMP, 1'b0);
            pkt_open = 1'b1;
        end else begin
            put_byte(BLE_STAMP, 1'b0);
        end
    endtask

    // advance the parser by one accepted item and queue the bytes it causes
    task automatic frame_midi_item(input t_in_item it);
        logic [7:0] b;
        logic [7:0] st;
        logic       flush;
        b = it.byte_value;
        burst_len = 0;
        if (it.kind == KIND_SENT) begin
            pkt_open = 1'b0;
        end else if (b == ST_ACT_SENSE || b == ST_CLOCK) begin
            put_head();
            put_byte(b, 1'b0);
        end else if (b == ST_SYSEX) begin
            run_status = ST_SYSEX;
            sysex_count = 5'd3;
            put_head();
            put_byte(ST_SYSEX, 1'b0);
        end else if (b == ST_EOX) begin
            run_status = ST_NONE;
            put_head();
            put_byte(ST_EOX, 1'b0);
        end else if (run_status == ST_SYSEX) begin
            // streamed sysex data, reopening the packet with a bare header
            if (!pkt_open) begin
                put_byte(BLE_STAMP, 1'b0);
                pkt_open = 1'b1;
                sysex_count = 5'd1;
            end
            sysex_count = sysex_count + 5'd1;
            flush = (sysex_count > SYSEX_FLUSH_COUNT);
            if (flush) begin
                sysex_count = 5'd0;
                pkt_open = 1'b0;
            end
            put_byte(b, flush);
        end else if (b[7]) begin
            run_status = b & STATUS_MASK;
            chan = b[3:0];
            if (status_data_len(run_status) == 2) begin
                data_left = 2'd2;
            end else if (status_data_len(run_status) == 1) begin
                data_left = 2'd1;
            end
        end else if (data_left == 2'd1) begin
            // final data byte completes the message under running status
            st = run_status | {4'h0, chan};
            data_left = 2'd0;
            case (status_data_len(run_status))
                2: begin
                    put_head();
                    put_byte(st, 1'b0);
                    put_byte(first_data, 1'b0);
                    put_byte(b, 1'b0);
                    data_left = 2'd2;
                end
                1: begin
                    put_head();
                    put_byte(st, 1'b0);
                    put_byte(b, 1'b0);
                    data_left = 2'd1;
                end
                default: ;
            endcase
        end else if (data_left == 2'd2) begin
            first_data = b;
            data_left = 2'd1;
        end
        if (burst_len > 0) burst[burst_len - 1].last = 1'b1;
        for (int i = 0; i < burst_len; i++) ble_bytes_due.push_back(burst[i]);
    endtask

    // offer one item, with random hold-off, and predict once it is taken
    task automatic send_item(input logic kind, input logic [7:0] value);
        t_in_item it;
        it.kind = kind;
        it.byte_value = value;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        frame_midi_item(it);
        items_sent++;
    endtask

    task automatic send_midi(input logic [7:0] value);
        send_item(KIND_MIDI, value);
    endtask

    task automatic send_sent();
        send_item(KIND_SENT, 8'($urandom_range(0, 255)));
    endtask

    // occasional real-time byte dropped into the middle of a message
    task automatic maybe_realtime();
        if ($urandom_range(0, 99) < 8) send_midi($urandom_range(0, 1) ? ST_CLOCK : ST_ACT_SENSE);
    endtask

    task automatic test_channel_voice();
        send_midi(8'h7F);
        send_midi(ST_NOTE_ON);
        send_midi(8'h00);
        send_midi(8'h7F);
        send_midi(8'h3C);
        send_midi(8'h40);
        send_midi(ST_BEND | 8'h0F);
        send_midi(8'h7F);
        send_midi(8'h00);
        send_midi(ST_PROG | 8'h05);
        send_midi(8'h12);
        send_midi(8'h13);
    endtask

    task automatic test_realtime();
        send_midi(ST_CLOCK);
        send_item(KIND_SENT, 8'hFF);
        send_midi(ST_ACT_SENSE);
    endtask

    task automatic test_sysex();
        send_midi(ST_SYSEX);
        send_midi(8'h7F);
        send_item(KIND_SENT, 8'h00);
        send_midi(8'h85);
        send_midi(ST_EOX);
    endtask

    task automatic test_stray_and_system();
        // data left pending when the status is cleared by an end of sysex
        send_midi(ST_POLY_PRESS | 8'h03);
        send_midi(8'h10);
        send_midi(ST_EOX);
        send_midi(8'h20);
        // undefined system byte switches to sysex streaming
        send_midi(8'hF5);
        send_midi(8'h11);
        send_midi(8'hFF);
    endtask

    task automatic test_random_traffic(input int n_items);
        int         goal;
        int         pick;
        int         reps;
        int         len;
        logic [7:0] b;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // channel message with running-status repeats, sometimes short a byte
                b[7:4] = 4'($urandom_range(8, 14));
                b[3:0] = 4'($urandom_range(0, 15));
                send_midi(b);
                reps = $urandom_range(1, 4);
                for (int r = 0; r < reps; r++) begin
                    for (int d = 0; d < status_data_len(b & STATUS_MASK); d++) begin
                        maybe_realtime();
                        if ($urandom_range(0, 19) != 0) send_midi(8'($urandom_range(0, 127)));
                    end
                end
            end else if (pick < 60) begin
                // sysex, now and then long enough to force a send
                send_midi(ST_SYSEX);
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 12);
                for (int i = 0; i < len; i++) begin
                    maybe_realtime();
                    if ($urandom_range(0, 29) == 0) send_sent();
                    if ($urandom_range(0, 9) == 0) begin
                        send_midi(8'($urandom_range(128, 239)));
                    end else begin
                        send_midi(8'($urandom_range(0, 127)));
                    end
                end
                if ($urandom_range(0, 9) != 0) send_midi(ST_EOX);
            end else if (pick < 70) begin
                send_midi($urandom_range(0, 1) ? ST_CLOCK : ST_ACT_SENSE);
            end else if (pick < 80) begin
                send_sent();
            end else if (pick < 90) begin
                // undefined system byte followed by streamed bytes
                do begin
                    b = 8'($urandom_range(241, 255));
                end while (b == ST_EOX || b == ST_CLOCK || b == ST_ACT_SENSE);
                send_midi(b);
                len = $urandom_range(0, 4);
                for (int i = 0; i < len; i++) send_midi(8'($urandom_range(0, 127)));
                if ($urandom_range(0, 1) != 0) send_midi(ST_EOX);
            end else begin
                send_midi(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // result side: random pop and in-order comparison
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (ble_bytes_due.size() == 0) begin
                    $display("%0t: unexpected item byte=%h flush=%b last=%b", $time,
                             o_item.out_byte, o_item.flush_after, o_item.last);
                    mismatch_count++;
                end else begin
                    if (o_item !== ble_bytes_due[0]) begin
                        $display("%0t: expected byte=%h flush=%b last=%b, actual byte=%h flush=%b last=%b",
                                 $time, ble_bytes_due[0].out_byte, ble_bytes_due[0].flush_after,
                                 ble_bytes_due[0].last, o_item.out_byte, o_item.flush_after,
                                 o_item.last);
                        mismatch_count++;
                    end
                    void'(ble_bytes_due.pop_front());
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        run_status  = ST_NONE;
        chan        = 4'h0;
        data_left   = 2'd0;
        first_data  = 8'h00;
        pkt_open    = 1'b0;
        sysex_count = 5'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_channel_voice();
        test_realtime();
        test_sysex();
        test_stray_and_system();

        test_random_traffic(150);
        send_idle_pct = 51;
        recv_idle_pct = 28;
        test_random_traffic(145);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(145);
        push <= 1'b0;

        // drain, then allow for any stray trailing bytes
        while (ble_bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
